// File: design/gpni_pkg.sv
// shared constants and control types for the gaussian pixel noise injector
`timescale 1ns / 1ps

package gpni_pkg;

    localparam int unsigned PIX_W      = 8;
    localparam int unsigned SIGMA_W    = 8;
    localparam int unsigned SEED_W     = 32;
    localparam int unsigned CLIP_W     = 24;
    localparam int unsigned DRAW_W     = 16;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned SCALE_W    = 17;
    localparam int unsigned SCALE_SHIFT = 15;

    localparam logic [SEED_W-1:0]  LCG_MUL   = 32'd1103515245;
    localparam logic [SEED_W-1:0]  LCG_ADD   = 32'd12345;
    localparam logic [SEED_W-1:0]  SEED_RST  = 32'd1;
    localparam logic [DRAW_W-1:0]  HALF_DRAW = 16'd16384;
    localparam logic [SCALE_W-1:0] SCALE_Q16 = 17'd71791;
    localparam logic [PIX_W-1:0]   PIX_MAX   = 8'd255;
    localparam logic [SIGMA_W-1:0] SIGMA_RST = 8'd0;

    // register index taken from paddr[2]
    localparam logic REG_SIGMA = 1'b0;
    localparam logic REG_SEED  = 1'b1;

    typedef struct packed {
        logic load;    // capture pixel, clear accumulator
        logic step;    // advance generator
        logic accum;   // add current draw into the sum
        logic mul1;    // magnitude times sigma
        logic mul2;    // times scale constant
        logic emit;    // clamp and load output register
    } cmd_t;

    typedef struct packed {
        logic out_full;
    } status_t;

endpackage

// File: design/gpni_ctrl.sv
// controller state machine sequencing draws, scaling and output
`timescale 1ns / 1ps

module gpni_ctrl #(
    parameter int unsigned DRAWS = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  gpni_pkg::status_t status,
    output gpni_pkg::cmd_t   cmd
);
    import gpni_pkg::*;

    localparam int unsigned CNT_W = $clog2(DRAWS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DRAWS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GEN  = 3'd1;
    localparam logic [2:0] ST_MUL1 = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_GEN;
                end
            end
            ST_GEN:
            begin
                // draw i is summed in the cycle after its generator step
                cmd.step  = (cnt_reg != CNT_LAST);
                cmd.accum = (cnt_reg != '0);
                if (cnt_reg == CNT_LAST)
                    state_next = ST_MUL1;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!status.out_full)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: design/gpni_dp.sv
// datapath: generator, draw sum, scaling multipliers, clamp and output register
`timescale 1ns / 1ps

module gpni_dp #(
    parameter int unsigned DRAWS = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  gpni_pkg::cmd_t                  cmd,
    output gpni_pkg::status_t               status,
    input  logic [gpni_pkg::PIX_W-1:0]      pixel_in,
    input  logic [gpni_pkg::SIGMA_W-1:0]    sigma,
    input  logic                            seed_load,
    input  logic [gpni_pkg::SEED_W-1:0]     seed,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [gpni_pkg::PIX_W-1:0]      pixel_out,
    output logic                            clipped,
    output logic [gpni_pkg::CLIP_W-1:0]     clip_count
);
    import gpni_pkg::*;

    localparam int unsigned MAG_W = $clog2(DRAWS * 16384 + 1);
    localparam int unsigned SUM_W = MAG_W + 1;
    localparam int unsigned P1_W  = MAG_W + SIGMA_W;
    localparam int unsigned P2_W  = P1_W + SCALE_W;
    localparam int unsigned NZ_W  = P2_W - SCALE_SHIFT;
    localparam int unsigned V_W   = NZ_W + 2;
    localparam logic signed [V_W-1:0] V_TOP = V_W'({PIX_MAX, 16'h0000});

    logic [SEED_W-1:0]       gen_reg;
    logic [SEED_W-1:0]       gen_next;
    logic signed [SUM_W-1:0] acc_reg;
    logic [PIX_W-1:0]        pix_reg;
    logic [P1_W-1:0]         p1_reg;
    logic [P2_W-1:0]         p2_reg;
    logic                    out_valid_reg;
    logic [PIX_W-1:0]        pixel_out_reg;
    logic                    clipped_reg;
    logic [CLIP_W-1:0]       clip_total_reg;

    logic signed [DRAW_W-1:0] draw;
    logic signed [SUM_W-1:0]  draw_ext;
    logic [SUM_W-1:0]         acc_abs;
    logic [MAG_W-1:0]         mag;
    logic [NZ_W-1:0]          noise_mag;
    logic signed [V_W-1:0]    pix_ext;
    logic signed [V_W-1:0]    nz_ext;
    logic signed [V_W-1:0]    v;
    logic                     over;
    logic                     under;
    logic [PIX_W-1:0]         result;

    assign gen_next  = gen_reg * LCG_MUL + LCG_ADD;
    assign draw      = $signed({1'b0, gen_reg[30:16]}) - $signed(HALF_DRAW);
    assign draw_ext  = {{(SUM_W-DRAW_W){draw[DRAW_W-1]}}, draw};
    assign acc_abs   = acc_reg[SUM_W-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign mag       = acc_abs[MAG_W-1:0];
    assign noise_mag = p2_reg[P2_W-1:SCALE_SHIFT];
    assign pix_ext   = $signed({{(V_W-PIX_W-FRAC_W){1'b0}}, pix_reg, {FRAC_W{1'b0}}});
    assign nz_ext    = $signed({2'b00, noise_mag});
    assign v         = acc_reg[SUM_W-1] ? (pix_ext - nz_ext) : (pix_ext + nz_ext);
    assign over      = v > V_TOP;
    assign under     = v[V_W-1];

    always_comb
    begin
        if (over)
            result = PIX_MAX;
        else if (under)
            result = '0;
        else
            result = v[FRAC_W+PIX_W-1:FRAC_W];
    end

    assign status.out_full = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg        <= SEED_RST;
            clip_total_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (seed_load)
                gen_reg <= seed;
            else if (cmd.step)
                gen_reg <= gen_next;

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                if ((over || under) && (clip_total_reg != {CLIP_W{1'b1}}))
                    clip_total_reg <= clip_total_reg + 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pix_reg <= pixel_in;
            acc_reg <= '0;
        end
        else if (cmd.accum)
            acc_reg <= acc_reg + draw_ext;

        if (cmd.mul1)
            p1_reg <= mag * sigma;
        if (cmd.mul2)
            p2_reg <= p1_reg * SCALE_Q16;

        if (cmd.emit)
        begin
            pixel_out_reg <= result;
            clipped_reg   <= over || under;
        end
    end

    // clip total after this item is what the result carries
    logic [CLIP_W-1:0] clip_shown_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            clip_shown_reg <= ((over || under) && (clip_total_reg != {CLIP_W{1'b1}}))
                              ? clip_total_reg + 1'b1 : clip_total_reg;
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign clipped    = clipped_reg;
    assign clip_count = clip_shown_reg;

endmodule

// File: design/gaussian_pixel_noise_injector.sv
// top level: apb registers, controller and datapath of the pixel noise injector
`timescale 1ns / 1ps

// Adds approximately Gaussian noise to one 8-bit grey pixel per item: the sum of
// DRAWS centred 15-bit draws from a linear congruential generator, scaled by
// noise_sigma * sqrt(1.2) in Q1.16, is added to the pixel, which is then clamped
// to 0..255 and truncated. After acceptance the generator runs first, advancing
// one step per cycle through a single 32x32 multiplier with each draw summed in
// the cycle after its step; then come the two scaling multiplies and the clamp,
// which loads the result. The next item is accepted on the cycle after that, so a
// new item is taken only once the last result is loaded; an item is accepted even
// while the previous result waits on the output, but its own result is held until
// the output is free.
// Writing noise_seed (address 0x4) reloads the generator; noise_sigma lies at 0x0.
// The 24-bit clip counter saturates and is cleared only by reset.
module gaussian_pixel_noise_injector #(
    parameter int unsigned DRAWS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel_in
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [7:0] pixel_out, [8] clipped, [32:9] clip_count
);
    import gpni_pkg::*;

    logic [SIGMA_W-1:0] sigma_reg;
    logic [SEED_W-1:0]  seed_reg;
    logic               cfg_wr;
    logic               seed_load;
    cmd_t               cmd;
    status_t            status;
    logic [PIX_W-1:0]   pixel_out;
    logic               clipped;
    logic [CLIP_W-1:0]  clip_count;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign seed_load = cfg_wr && (paddr[2] == REG_SEED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg <= SIGMA_RST;
            seed_reg  <= SEED_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_SIGMA: sigma_reg <= pwdata[SIGMA_W-1:0];
                REG_SEED:  seed_reg  <= pwdata;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SIGMA: prdata = {{(32-SIGMA_W){1'b0}}, sigma_reg};
            REG_SEED:  prdata = seed_reg;
            default:   prdata = '0;
        endcase
    end

    gpni_ctrl #(
        .DRAWS (DRAWS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gpni_dp #(
        .DRAWS (DRAWS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .pixel_in   (s_tdata),
        .sigma      (sigma_reg),
        .seed_load  (seed_load),
        .seed       (pwdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .pixel_out  (pixel_out),
        .clipped    (clipped),
        .clip_count (clip_count)
    );

    assign m_tdata = {7'b0, clip_count, clipped, pixel_out};

    a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (s_tvalid && s_tready))
        else $error("item loaded without handshake");

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while one is in work");

    a_emit_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !status.out_full)
        else $error("result overwrote a pending output");

    a_emit_shows_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> m_tvalid)
        else $error("emitted result not presented");

endmodule

// File: tb/tb_gaussian_pixel_noise_injector.sv
// testbench for the gaussian pixel noise injector: streamed pixels checked against a noise predictor
`timescale 1ns / 1ps

module tb_gaussian_pixel_noise_injector;
    import gpni_pkg::*;

    localparam int unsigned DRAWS       = 10;
    localparam int unsigned LATENCY     = DRAWS + 5;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RAND_PHASES = 12;
    localparam int unsigned PHASE_ITEMS = 142;

    typedef struct packed {
        logic [PIX_W-1:0]  pix;
        logic              clip;
        logic [CLIP_W-1:0] count;
    } noisy_px_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] pixel_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // [7:0] pixel_out, [8] clipped, [32:9] clip_count

    // predictor state
    logic [SIGMA_W-1:0] sigma_cfg = SIGMA_RST;
    logic [SEED_W-1:0]  gen_st    = SEED_RST;
    logic [CLIP_W-1:0]  clip_tot  = '0;

    logic [PIX_W-1:0] pix_q[$];
    noisy_px_t        noisy_q[$];
    noisy_px_t        seen_px;
    bit               in_taken  = 1'b0;
    bit               no_idle   = 1'b0;
    int               err_cnt   = 0;
    int unsigned      cycle_cnt = 0;

    gaussian_pixel_noise_injector #(
        .DRAWS(DRAWS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // steps the generator DRAWS times and returns the noisy pixel
    function automatic noisy_px_t apply_noise(input logic [PIX_W-1:0] pix);
        noisy_px_t res;
        int        draw_sum;
        longint    mag;
        longint    level;
        draw_sum = 0;
        for (int i = 0; i < DRAWS; i++)
        begin
            gen_st = gen_st * LCG_MUL + LCG_ADD;
            draw_sum += int'(gen_st[30:16]) - int'(HALF_DRAW);
        end
        mag = longint'(draw_sum < 0 ? -draw_sum : draw_sum);
        mag = (mag * longint'(sigma_cfg) * longint'(SCALE_Q16)) >> SCALE_SHIFT;
        level = (longint'(pix) <<< FRAC_W) + (draw_sum < 0 ? -mag : mag);
        if (level > (longint'(PIX_MAX) <<< FRAC_W))
        begin
            res.pix  = PIX_MAX;
            res.clip = 1'b1;
        end
        else if (level < 0)
        begin
            res.pix  = '0;
            res.clip = 1'b1;
        end
        else
        begin
            res.pix  = level[FRAC_W+PIX_W-1:FRAC_W];
            res.clip = 1'b0;
        end
        if (res.clip && clip_tot != '1)
            clip_tot++;
        res.count = clip_tot;
        return res;
    endfunction

    // write one register, then read it back
    task automatic reg_write(input logic idx, input logic [31:0] val);
        logic [31:0] want;
        want = (idx == REG_SIGMA) ? {24'd0, val[SIGMA_W-1:0]} : val;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_SIGMA)
            sigma_cfg = val[SIGMA_W-1:0];
        else
            gen_st = val;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            $error("prdata mismatch at paddr %0d: expected %h, actual %h", {idx, 2'b00}, want,
                   prdata);
            err_cnt++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pix_q.size() != 0 || noisy_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // driver: one item presented from the pending queue, held until taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (!(s_tvalid && !in_taken))
            begin
                if (pix_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 8))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pix_q[0];
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= no_idle || ($urandom_range(0, 99) >= 8);
        end
        in_taken = 1'b0;
    end

    // monitor: predict on each accepted pixel, check each accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                noisy_q.push_back(apply_noise(s_tdata));
                void'(pix_q.pop_front());
                in_taken = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                if (noisy_q.size() == 0)
                begin
                    $error("unexpected item on output: m_tdata %h", m_tdata);
                    err_cnt++;
                end
                else
                begin
                    seen_px = noisy_q.pop_front();
                    if (m_tdata[7:0] !== seen_px.pix)
                    begin
                        $error("pixel_out mismatch: expected %0d, actual %0d", seen_px.pix,
                               m_tdata[7:0]);
                        err_cnt++;
                    end
                    if (m_tdata[8] !== seen_px.clip)
                    begin
                        $error("clipped mismatch: expected %0d, actual %0d", seen_px.clip,
                               m_tdata[8]);
                        err_cnt++;
                    end
                    if (m_tdata[32:9] !== seen_px.count)
                    begin
                        $error("clip_count mismatch: expected %0d, actual %0d", seen_px.count,
                               m_tdata[32:9]);
                        err_cnt++;
                    end
                end
            end
        end
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int unsigned sig;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: zero sigma passes pixels through, generator still runs
        pix_q = {8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'h55, 8'hAA};
        wait_drained();

        // full sigma: clips at both ends
        reg_write(REG_SIGMA, 32'd255);
        pix_q = {8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd128};
        wait_drained();

        reg_write(REG_SEED, 32'd0);
        reg_write(REG_SIGMA, 32'hFFFF_FF01);
        pix_q = {8'd0, 8'd255, 8'd100};
        wait_drained();

        reg_write(REG_SEED, 32'hFFFF_FFFF);
        reg_write(REG_SIGMA, 32'd8);
        pix_q = {8'd0, 8'd255, 8'd3, 8'd252, 8'd128};
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case ($urandom_range(0, 4))
                0: sig = 0;
                1: sig = 255;
                2: sig = 1;
                3: sig = $urandom_range(2, 16);
                default: sig = $urandom_range(0, 255);
            endcase
            reg_write(REG_SIGMA, ($urandom() & 32'hFFFF_FF00) | sig);
            if ($urandom_range(0, 1))
                reg_write(REG_SEED, $urandom());
            // one phase runs with no stalls on either side
            no_idle = (ph == 5);
            repeat (PHASE_ITEMS)
            begin
                case ($urandom_range(0, 9))
                    0: pix_q.push_back(8'd0);
                    1: pix_q.push_back(PIX_MAX);
                    default: pix_q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            wait_drained();
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (4 * LATENCY) @(posedge clk);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
design/gpni_pkg.sv
design/gpni_ctrl.sv
design/gpni_dp.sv
design/gaussian_pixel_noise_injector.sv
tb/tb_gaussian_pixel_noise_injector.sv
